FILE: design/tfp_pkg.sv
package tfp_pkg;

   localparam logic [3:0] CODE_LOGIN     = 4'd0;
   localparam logic [3:0] CODE_HEARTBEAT = 4'd1;
   localparam logic [3:0] CODE_TIME_REQ  = 4'd2;
   localparam logic [3:0] CODE_POSITION  = 4'd3;
   localparam logic [3:0] CODE_ALARM     = 4'd4;
   localparam logic [3:0] CODE_CMD_RSP   = 4'd5;
   localparam logic [3:0] CODE_CRC_ERR   = 4'd6;
   localparam logic [3:0] CODE_NO_LOGIN  = 4'd7;
   localparam logic [3:0] CODE_UNKNOWN   = 4'd8;

   localparam logic [7:0] TYPE_LOGIN     = 8'h01;
   localparam logic [7:0] TYPE_HEARTBEAT = 8'h13;
   localparam logic [7:0] TYPE_TIME_REQ  = 8'h8A;
   localparam logic [7:0] TYPE_POSITION  = 8'h22;
   localparam logic [7:0] TYPE_ALARM     = 8'h26;
   localparam logic [7:0] TYPE_CMD_RSP   = 8'h21;

   localparam logic [7:0] START_SHORT = 8'h78;
   localparam logic [7:0] START_LONG  = 8'h79;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam int CAP_DEPTH = 35;

   // one completed frame handed from the front end to the decoder
   typedef struct packed {
      logic [CAP_DEPTH*8-1:0] capture;
      logic                   long_format;
      logic                   crc_ok;
      logic [7:0]             frame_type;
   } frame_type_t_type;

   typedef struct packed {
      logic [3:0]  result_code;
      logic [63:0] device_id;
      logic [47:0] date_time;
      logic [31:0] latitude;
      logic [31:0] longitude;
      logic [7:0]  speed;
      logic [9:0]  heading;
      logic [2:0]  course_flags;
      logic [7:0]  terminal_info;
      logic [7:0]  voltage_level;
      logic [7:0]  signal_strength;
      logic [7:0]  alarm_code;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: design/tfp_front.sv
module tfp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [7:0]                in_byte,
   output logic                      in_ready,
   output logic                      frm_valid,
   output tfp_pkg::frame_type_t_type frm,
   input  logic                      frm_ready
);

   localparam logic [2:0] PH_HUNT1 = 3'd0;
   localparam logic [2:0] PH_HUNT2 = 3'd1;
   localparam logic [2:0] PH_LENHI = 3'd2;
   localparam logic [2:0] PH_LENLO = 3'd3;
   localparam logic [2:0] PH_BODY  = 3'd4;
   localparam logic [2:0] PH_CRCHI = 3'd5;
   localparam logic [2:0] PH_CRCLO = 3'd6;
   localparam logic [2:0] PH_STOP  = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic        long_ff, long_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  cap_ff [tfp_pkg::CAP_DEPTH];
   logic        cap_clr;
   logic        cap_we;
   logic [16:0] cap_off;
   logic        emit;
   logic        fire;
   logic [15:0] pos_inc;
   logic [15:0] len_full;

   // stall only when a finished frame cannot enter the queue
   assign in_ready = frm_ready || !(phase_ff == PH_STOP && pos_ff != 16'd0);
   assign fire     = in_valid && in_ready;
   assign pos_inc  = pos_ff + 16'd1;
   assign len_full = len_ff | {8'h00, in_byte};

   always_comb begin
      phase_in = phase_ff;
      long_in  = long_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      rcrc_in  = rcrc_ff;
      type_in  = type_ff;
      cap_clr  = 1'b0;
      cap_we   = 1'b0;
      cap_off  = 17'd0;
      emit     = 1'b0;
      case (phase_ff)
         PH_HUNT1, PH_HUNT2: begin
            if (phase_ff == PH_HUNT2 &&
                in_byte == (long_ff ? tfp_pkg::START_LONG : tfp_pkg::START_SHORT)) begin
               cap_clr  = 1'b1;
               crc_in   = tfp_pkg::CRC_INIT;
               rcrc_in  = 16'd0;
               len_in   = 16'd0;
               type_in  = 8'd0;
               pos_in   = 16'd0;
               phase_in = long_ff ? PH_LENHI : PH_LENLO;
            end else if (in_byte == tfp_pkg::START_SHORT) begin
               long_in  = 1'b0;
               phase_in = PH_HUNT2;
            end else if (in_byte == tfp_pkg::START_LONG) begin
               long_in  = 1'b1;
               phase_in = PH_HUNT2;
            end else begin
               phase_in = PH_HUNT1;
            end
         end
         PH_LENHI: begin
            len_in   = {in_byte, 8'h00};
            cap_we   = 1'b1;
            cap_off  = 17'd2;
            crc_in   = tfp_pkg::crc_byte(crc_ff, in_byte);
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            len_in   = len_full;
            cap_we   = 1'b1;
            cap_off  = long_ff ? 17'd3 : 17'd2;
            crc_in   = tfp_pkg::crc_byte(crc_ff, in_byte);
            pos_in   = 16'd0;
            phase_in = (len_full < 16'd3) ? PH_HUNT1 : PH_BODY;
         end
         PH_BODY: begin
            if (pos_ff == 16'd0) begin
               type_in = in_byte;
            end
            cap_we   = 1'b1;
            cap_off  = {1'b0, pos_ff} + (long_ff ? 17'd4 : 17'd3);
            crc_in   = tfp_pkg::crc_byte(crc_ff, in_byte);
            pos_in   = pos_inc;
            if ({1'b0, pos_inc} + 17'd2 >= {1'b0, len_ff}) begin
               phase_in = PH_CRCHI;
            end
         end
         PH_CRCHI: begin
            rcrc_in  = {in_byte, 8'h00};
            phase_in = PH_CRCLO;
         end
         PH_CRCLO: begin
            rcrc_in  = rcrc_ff | {8'h00, in_byte};
            pos_in   = 16'd0;
            phase_in = PH_STOP;
         end
         default: begin
            if (pos_ff != 16'd0) begin
               emit     = 1'b1;
               pos_in   = 16'd0;
               phase_in = PH_HUNT1;
            end else begin
               pos_in = pos_inc;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         long_ff  <= 1'b0;
         pos_ff   <= 16'd0;
         len_ff   <= 16'd0;
         crc_ff   <= tfp_pkg::CRC_INIT;
         rcrc_ff  <= 16'd0;
         type_ff  <= 8'd0;
         for (int i = 0; i < tfp_pkg::CAP_DEPTH; i++) cap_ff[i] <= 8'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         long_ff  <= long_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         rcrc_ff  <= rcrc_in;
         type_ff  <= type_in;
         if (cap_clr) begin
            for (int i = 2; i < tfp_pkg::CAP_DEPTH; i++) cap_ff[i] <= 8'd0;
            cap_ff[0] <= in_byte;
            cap_ff[1] <= in_byte;
         end else if (cap_we) begin
            for (int i = 0; i < tfp_pkg::CAP_DEPTH; i++) begin
               if (cap_off == 17'(i)) cap_ff[i] <= in_byte;
            end
         end
      end
   end

   assign frm_valid = fire && emit;

   always_comb begin
      for (int i = 0; i < tfp_pkg::CAP_DEPTH; i++) begin
         frm.capture[(tfp_pkg::CAP_DEPTH-1-i)*8 +: 8] = cap_ff[i];
      end
      frm.long_format = long_ff;
      frm.crc_ok      = (~crc_ff) == rcrc_ff;
      frm.frame_type  = type_ff;
   end

endmodule

FILE: design/tfp_queue.sv
module tfp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_valid,
   input  tfp_pkg::frame_type_t_type wr_data,
   output logic                      wr_ready,
   output logic                      rd_valid,
   output tfp_pkg::frame_type_t_type rd_data,
   input  logic                      rd_ready
);

   tfp_pkg::frame_type_t_type slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       wr_fire, rd_fire;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = slot_ff[rptr_ff];
   assign wr_fire  = wr_valid && wr_ready;
   assign rd_fire  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr_fire) slot_ff[wptr_ff] <= wr_data;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (wr_fire) wptr_ff <= ~wptr_ff;
         if (rd_fire) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_fire} - {1'b0, rd_fire};
      end
   end

endmodule

FILE: design/tfp_decode.sv
module tfp_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      frm_valid,
   input  tfp_pkg::frame_type_t_type frm,
   output logic                      frm_ready,
   output logic                      out_valid,
   output tfp_pkg::result_type       out_data,
   input  logic                      out_ready
);

   logic                logged_ff;
   logic [63:0]         id_ff;
   logic                valid_ff;
   tfp_pkg::result_type res_ff, res_in;
   logic                login_ok;
   logic [7:0]          cb [tfp_pkg::CAP_DEPTH];
   logic [15:0]         course;

   assign frm_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = res_ff;

   always_comb begin
      for (int i = 0; i < tfp_pkg::CAP_DEPTH; i++) begin
         cb[i] = frm.capture[(tfp_pkg::CAP_DEPTH-1-i)*8 +: 8];
      end
      course   = {cb[20], cb[21]};
      login_ok = 1'b0;
      res_in   = '0;
      if (!frm.crc_ok) begin
         res_in.result_code = tfp_pkg::CODE_CRC_ERR;
      end else if (frm.long_format) begin
         if (!logged_ff) res_in.result_code = tfp_pkg::CODE_NO_LOGIN;
         else if (frm.frame_type == tfp_pkg::TYPE_CMD_RSP)
            res_in.result_code = tfp_pkg::CODE_CMD_RSP;
         else res_in.result_code = tfp_pkg::CODE_UNKNOWN;
      end else if (frm.frame_type != tfp_pkg::TYPE_LOGIN && !logged_ff) begin
         res_in.result_code = tfp_pkg::CODE_NO_LOGIN;
      end else begin
         case (frm.frame_type)
            tfp_pkg::TYPE_LOGIN: begin
               login_ok = 1'b1;
               res_in.result_code = tfp_pkg::CODE_LOGIN;
            end
            tfp_pkg::TYPE_HEARTBEAT: begin
               res_in.result_code     = tfp_pkg::CODE_HEARTBEAT;
               res_in.terminal_info   = cb[4];
               res_in.voltage_level   = cb[5];
               res_in.signal_strength = cb[6];
            end
            tfp_pkg::TYPE_TIME_REQ: res_in.result_code = tfp_pkg::CODE_TIME_REQ;
            tfp_pkg::TYPE_POSITION, tfp_pkg::TYPE_ALARM: begin
               res_in.result_code  = (frm.frame_type == tfp_pkg::TYPE_ALARM) ?
                                     tfp_pkg::CODE_ALARM : tfp_pkg::CODE_POSITION;
               res_in.date_time    = {cb[4], cb[5], cb[6], cb[7], cb[8], cb[9]};
               res_in.latitude     = {cb[11], cb[12], cb[13], cb[14]};
               res_in.longitude    = {cb[15], cb[16], cb[17], cb[18]};
               res_in.speed        = cb[19];
               res_in.heading      = course[9:0];
               res_in.course_flags = course[12:10];
               if (frm.frame_type == tfp_pkg::TYPE_ALARM) begin
                  res_in.terminal_info   = cb[31];
                  res_in.voltage_level   = cb[32];
                  res_in.signal_strength = cb[33];
                  res_in.alarm_code      = cb[34];
               end
            end
            default: res_in.result_code = tfp_pkg::CODE_UNKNOWN;
         endcase
      end
      res_in.device_id = login_ok ? {cb[4], cb[5], cb[6], cb[7], cb[8], cb[9], cb[10], cb[11]}
                                  : id_ff;
   end

   always_ff @(posedge clock) begin
      if (frm_valid && frm_ready) res_ff <= res_in;
      if (reset) begin
         logged_ff <= 1'b0;
         id_ff     <= 64'd0;
         valid_ff  <= 1'b0;
      end else begin
         if (frm_valid && frm_ready) begin
            valid_ff <= 1'b1;
            if (login_ok) begin
               logged_ff <= 1'b1;
               id_ff     <= res_in.device_id;
            end
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: design/tracker_frame_parser.sv
// Byte-serial tracker frame parser. One byte is taken per cycle on req_ unless stalled;
// each complete frame yields one result on rsp_ after its second stop byte (none for
// resync bytes or frames with a length below three). A byte passes the single CRC-16/X.25
// byte step in the front end; a two-entry frame queue and the decoder's output register
// let the input run on while results wait. Input stalls only when the queue is full.
module tracker_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] data_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] device_id, [111:64] date_time, [143:112] latitude, [175:144] longitude,
   // [183:176] speed, [193:184] heading, [196:194] course_flags, [204:197] terminal_info,
   // [212:205] voltage_level, [220:213] signal_strength, [228:221] alarm_code, zero pad
   output logic [231:0] rsp_tdata,
   output logic [3:0]   rsp_tuser   // [3:0] result_code
);

   tfp_pkg::frame_type_t_type fq_in, fq_out;
   logic fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;
   tfp_pkg::result_type res;

   tfp_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_byte (req_tdata), .in_ready (req_tready),
      .frm_valid (fq_in_valid), .frm (fq_in), .frm_ready (fq_in_ready)
   );

   tfp_queue u_queue (
      .clock, .reset,
      .wr_valid (fq_in_valid), .wr_data (fq_in), .wr_ready (fq_in_ready),
      .rd_valid (fq_out_valid), .rd_data (fq_out), .rd_ready (fq_out_ready)
   );

   tfp_decode u_decode (
      .clock, .reset,
      .frm_valid (fq_out_valid), .frm (fq_out), .frm_ready (fq_out_ready),
      .out_valid (rsp_tvalid), .out_data (res), .out_ready (rsp_tready)
   );

   assign rsp_tuser = res.result_code;
   assign rsp_tdata = {3'b000, res.alarm_code, res.signal_strength, res.voltage_level,
                       res.terminal_info, res.course_flags, res.heading, res.speed,
                       res.longitude, res.latitude, res.date_time, res.device_id};

endmodule

FILE: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tfp_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [231:0] rsp_tdata;
   logic [3:0]   rsp_tuser;

   tracker_frame_parser uut (.*);

   always #5 clock = ~clock;

   typedef enum logic [2:0] {
      P_HUNT1, P_HUNT2, P_LENHI, P_LENLO, P_BODY, P_CRCHI, P_CRCLO, P_STOP
   } phase_type;

   // parser copy
   phase_type   m_phase;
   logic        m_long;
   logic [15:0] m_pos, m_len, m_crc, m_rxcrc;
   logic [7:0]  m_type;
   logic [7:0]  m_cap [CAP_DEPTH];
   logic        m_logged;
   logic [63:0] m_devid;

   result_type  frame_results [$];
   int          errors = 0;
   int          n_bytes = 0;
   int          n_results = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   logic [7:0]  frame [$];

   function automatic logic [15:0] x25_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
      return r;
   endfunction

   function automatic logic [63:0] cap_word(int off, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
         v = (v << 8) | {56'd0, ((off + i) < CAP_DEPTH ? m_cap[off + i] : 8'h00)};
      return v;
   endfunction

   function automatic void hunt_start(logic [7:0] b);
      if (b == START_SHORT) begin
         m_long = 1'b0;
         m_phase = P_HUNT2;
      end else if (b == START_LONG) begin
         m_long = 1'b1;
         m_phase = P_HUNT2;
      end else begin
         m_phase = P_HUNT1;
      end
   endfunction

   function automatic void decode_course(ref result_type r);
      logic [15:0] course;
      course = 16'(cap_word(20, 2));
      r.date_time = 48'(cap_word(4, 6));
      r.latitude = 32'(cap_word(11, 4));
      r.longitude = 32'(cap_word(15, 4));
      r.speed = 8'(cap_word(19, 1));
      r.heading = course[9:0];
      r.course_flags = {course[12], course[11], course[10]};
   endfunction

   function automatic void decode_frame();
      result_type r;
      r = '0;
      if (~m_crc != m_rxcrc) r.result_code = CODE_CRC_ERR;
      else if (m_long) begin
         if (!m_logged) r.result_code = CODE_NO_LOGIN;
         else if (m_type == TYPE_CMD_RSP) r.result_code = CODE_CMD_RSP;
         else r.result_code = CODE_UNKNOWN;
      end else if (m_type != TYPE_LOGIN && !m_logged) r.result_code = CODE_NO_LOGIN;
      else begin
         case (m_type)
            TYPE_LOGIN: begin
               m_devid = cap_word(4, 8);
               m_logged = 1'b1;
               r.result_code = CODE_LOGIN;
            end
            TYPE_HEARTBEAT: begin
               r.result_code = CODE_HEARTBEAT;
               r.terminal_info = 8'(cap_word(4, 1));
               r.voltage_level = 8'(cap_word(5, 1));
               r.signal_strength = 8'(cap_word(6, 1));
            end
            TYPE_TIME_REQ: r.result_code = CODE_TIME_REQ;
            TYPE_POSITION: begin
               r.result_code = CODE_POSITION;
               decode_course(r);
            end
            TYPE_ALARM: begin
               r.result_code = CODE_ALARM;
               decode_course(r);
               r.terminal_info = 8'(cap_word(31, 1));
               r.voltage_level = 8'(cap_word(32, 1));
               r.signal_strength = 8'(cap_word(33, 1));
               r.alarm_code = 8'(cap_word(34, 1));
            end
            default: r.result_code = CODE_UNKNOWN;
         endcase
      end
      r.device_id = m_devid;
      frame_results.push_back(r);
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      int hdr;
      hdr = m_long ? 4 : 3;
      case (m_phase)
         P_HUNT1: hunt_start(b);
         P_HUNT2: begin
            if (b == (m_long ? START_LONG : START_SHORT)) begin
               foreach (m_cap[i]) m_cap[i] = 8'h00;
               m_cap[0] = b;
               m_cap[1] = b;
               m_crc = CRC_INIT;
               m_rxcrc = '0;
               m_len = '0;
               m_type = '0;
               m_pos = '0;
               m_phase = m_long ? P_LENHI : P_LENLO;
            end else hunt_start(b);
         end
         P_LENHI: begin
            m_len = {b, 8'h00};
            m_cap[2] = b;
            m_crc = x25_step(m_crc, b);
            m_phase = P_LENLO;
         end
         P_LENLO: begin
            m_len = m_len | {8'h00, b};
            m_cap[hdr - 1] = b;
            m_crc = x25_step(m_crc, b);
            m_pos = '0;
            m_phase = (m_len < 16'd3) ? P_HUNT1 : P_BODY;
         end
         P_BODY: begin
            if (m_pos == 16'd0) m_type = b;
            if (hdr + int'(m_pos) < CAP_DEPTH) m_cap[hdr + int'(m_pos)] = b;
            m_crc = x25_step(m_crc, b);
            m_pos = m_pos + 16'd1;
            if (32'(m_pos) + 32'd2 >= 32'(m_len)) m_phase = P_CRCHI;
         end
         P_CRCHI: begin
            m_rxcrc = {b, 8'h00};
            m_phase = P_CRCLO;
         end
         P_CRCLO: begin
            m_rxcrc = m_rxcrc | {8'h00, b};
            m_pos = '0;
            m_phase = P_STOP;
         end
         default: begin
            m_pos = m_pos + 16'd1;
            if (m_pos >= 16'd2) begin
               decode_frame();
               m_pos = '0;
               m_phase = P_HUNT1;
            end
         end
      endcase
   endfunction

   task automatic send_byte(logic [7:0] b);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      parse_byte(b);
      n_bytes++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      while (frame.size() > 0) send_byte(frame.pop_front());
   endtask

   // build a frame into the queue; body = type + info + serial
   task automatic build_frame(bit lng, logic [7:0] ftype, int info_len, bit bad_crc);
      logic [15:0] len, crc;
      logic [7:0]  b;
      len = 16'(info_len + 5);
      frame.delete();
      crc = CRC_INIT;
      b = lng ? START_LONG : START_SHORT;
      frame.push_back(b);
      frame.push_back(b);
      if (lng) begin
         frame.push_back(len[15:8]);
         crc = x25_step(crc, len[15:8]);
      end
      frame.push_back(len[7:0]);
      crc = x25_step(crc, len[7:0]);
      frame.push_back(ftype);
      crc = x25_step(crc, ftype);
      for (int i = 0; i < info_len + 2; i++) begin
         b = 8'($urandom);
         frame.push_back(b);
         crc = x25_step(crc, b);
      end
      crc = ~crc;
      if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
      frame.push_back(crc[15:8]);
      frame.push_back(crc[7:0]);
      frame.push_back(8'h0D);
      frame.push_back(8'h0A);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (frame_results.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(7))
         0: return TYPE_LOGIN;
         1: return TYPE_HEARTBEAT;
         2: return TYPE_TIME_REQ;
         3: return TYPE_POSITION;
         4: return TYPE_ALARM;
         5: return TYPE_CMD_RSP;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_info(logic [7:0] t);
      if ($urandom_range(9) == 0) return $urandom_range(0, 40);
      case (t)
         TYPE_LOGIN: return 8;
         TYPE_HEARTBEAT: return 5;
         TYPE_POSITION: return 26;
         TYPE_ALARM: return 33;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.result_code = rsp_tuser;
         got.device_id = rsp_tdata[63:0];
         got.date_time = rsp_tdata[111:64];
         got.latitude = rsp_tdata[143:112];
         got.longitude = rsp_tdata[175:144];
         got.speed = rsp_tdata[183:176];
         got.heading = rsp_tdata[193:184];
         got.course_flags = rsp_tdata[196:194];
         got.terminal_info = rsp_tdata[204:197];
         got.voltage_level = rsp_tdata[212:205];
         got.signal_strength = rsp_tdata[220:213];
         got.alarm_code = rsp_tdata[228:221];
         n_results++;
         if (frame_results.size() == 0) begin
            $display("%0t: unexpected result code %0d", $time, got.result_code);
            errors++;
         end else begin
            want = frame_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

   task automatic test_directed();
      // refused before login, then login, every type, broken starts, short lengths
      build_frame(0, TYPE_HEARTBEAT, 5, 0); send_frame();
      build_frame(1, TYPE_CMD_RSP, 3, 0); send_frame();
      build_frame(0, TYPE_LOGIN, 8, 1); send_frame();
      send_byte(8'h78); send_byte(8'h79); send_byte(8'h79); send_byte(8'h01);
      send_byte(8'h00); send_byte(8'hFF);
      send_byte(8'h78); send_byte(8'h78); send_byte(8'h02);
      build_frame(0, TYPE_LOGIN, 8, 0); send_frame();
      build_frame(0, TYPE_HEARTBEAT, 5, 0); send_frame();
      build_frame(0, TYPE_TIME_REQ, 0, 0); send_frame();
      build_frame(0, TYPE_POSITION, 26, 0); send_frame();
      build_frame(0, TYPE_ALARM, 33, 0); send_frame();
      build_frame(0, TYPE_ALARM, 2, 0); send_frame();
      build_frame(0, TYPE_CMD_RSP, 2, 0); send_frame();
      build_frame(1, TYPE_CMD_RSP, 40, 0); send_frame();
      build_frame(1, TYPE_POSITION, 26, 0); send_frame();
      build_frame(0, 8'hFF, 0, 0); send_frame();
      build_frame(0, 8'h00, 1, 1); send_frame();
      wait_drain();
   endtask

   task automatic test_random(int s_idle, int r_idle, int n);
      int start;
      send_idle = s_idle;
      recv_idle = r_idle;
      start = n_bytes;
      while (n_bytes - start < n) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte($urandom_range(9) < 3 ? 8'h78 : 8'($urandom));
         end else begin
            build_frame($urandom_range(5) == 0, pick_type(), 0, $urandom_range(9) == 0);
            frame.delete();
            begin
               logic [7:0] t;
               t = pick_type();
               build_frame(t == TYPE_CMD_RSP ? 1'($urandom_range(1)) : $urandom_range(7) == 0,
                           t, pick_info(t), $urandom_range(11) == 0);
            end
            send_frame();
         end
         if ($urandom_range(60) == 0) wait_drain();
      end
      wait_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      m_phase = P_HUNT1;
      m_long = 0; m_pos = 0; m_len = 0; m_crc = CRC_INIT; m_rxcrc = 0; m_type = 0;
      foreach (m_cap[i]) m_cap[i] = 8'h00;
      m_logged = 0; m_devid = 0;
      test_directed();
      test_random(37, 63, 430);
      test_random(63, 37, 430);
      test_random(0, 0, 430);
      $display("Sent %0d bytes, checked %0d frame results across all frame types.",
               n_bytes, n_results);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
